### hw/rtl/rdq_pkg.sv
// Package for the ring deque with cursor: command codes, controller states
// and the fixed widths of the transaction fields. No dependencies.
package rdq_pkg;

    localparam int CMD_W   = 3;
    localparam int DATA_IO_W = 32;
    localparam int IDX_W   = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_SHIFT   = 3'd1,
        CMD_POP     = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_SEEK    = 3'd4,
        CMD_RESTART = 3'd5,
        CMD_CLEAR   = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DONE
    } state_t;

endpackage

### hw/rtl/rdq_ifs.sv
// Valid/ready channel interfaces for the ring deque: command and response.
// Depends on rdq_pkg for the field widths.
interface rdq_req_if;
    logic                          valid;
    logic                          ready;
    logic [rdq_pkg::CMD_W-1:0]     cmd;
    logic [rdq_pkg::DATA_IO_W-1:0] data_in;
    logic [rdq_pkg::IDX_W-1:0]     index;

    modport source (output valid, cmd, data_in, index, input ready);
    modport sink (input valid, cmd, data_in, index, output ready);
endinterface

interface rdq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [rdq_pkg::DATA_IO_W-1:0] data_out;
    logic [rdq_pkg::IDX_W-1:0]     slot;
    logic [rdq_pkg::IDX_W-1:0]     occupancy;

    modport source (output valid, ok, data_out, slot, occupancy, input ready);
    modport sink (input valid, ok, data_out, slot, occupancy, output ready);
endinterface

### hw/rtl/rdq_store.sv
// Slot memory of the ring deque: one write port, one synchronous read port
// with registered read data that holds while no read is issued. No dependencies.
module rdq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 4
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ring_deque_with_cursor.sv
// Ring deque with a browsing cursor: top level, controller and response register.
// Depends on rdq_pkg, rdq_req_if, rdq_rsp_if and rdq_store.
//
// Usage:
//   req carries one command per transaction (push, shift, pop, remove, seek,
//   restart cursor, clear) with data_in and index; rsp returns exactly one
//   transaction per command with ok, data_out, slot and occupancy after it.
//   The store keeps at most DEPTH-1 entries in a single-port-read memory.
// Command flow:
//   A taken command ends in S_DONE, which loads the response register once it
//   is free and returns to S_IDLE; req is ready again as the result appears on
//   rsp. A remove that closes a gap walks the moved entries before S_DONE, each
//   entry one memory read (S_MOVE_RD) and one memory write (S_MOVE_WR).
//   Commands are taken one at a time.
// Reset:
//   rst_n clears head, tail and cursor to slot 0 (empty store) and drops
//   rsp.valid. Memory contents are not cleared; no clearing pass is needed.
// Stall:
//   A result held on rsp while rsp.ready is low does not block the next
//   command; a second finished result waits inside until rsp frees up.
module ring_deque_with_cursor #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    rdq_req_if.sink      req,
    rdq_rsp_if.source    rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int DIO_W = rdq_pkg::DATA_IO_W;
    localparam int IDX_W = rdq_pkg::IDX_W;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST : p - 1'b1;
    endfunction

    function automatic logic in_span(input logic [PTR_W-1:0] p,
                                     input logic [PTR_W-1:0] h,
                                     input logic [PTR_W-1:0] t);
        if (h <= t)
        begin
            return (p >= h) && (p < t);
        end
        return (p >= h) || (p < t);
    endfunction

    rdq_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] cursor_reg, cursor_next;

    // gap-closing walk: current destination, last source slot, direction
    logic [PTR_W-1:0] mv_pos_reg, mv_pos_next;
    logic [PTR_W-1:0] mv_end_reg, mv_end_next;
    logic             mv_down_reg, mv_down_next;
    logic [PTR_W-1:0] mv_src;

    // finished result waiting for the response register
    logic             res_ok_reg, res_ok_next;
    logic             res_rd_reg, res_rd_next;
    logic [PTR_W-1:0] res_slot_reg, res_slot_next;

    logic             rsp_valid_reg;
    logic             out_ok_reg;
    logic [DIO_W-1:0] out_data_reg;
    logic [IDX_W-1:0] out_slot_reg;
    logic [IDX_W-1:0] out_occ_reg;
    logic             load_out;

    logic                  mem_we;
    logic [PTR_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [PTR_W-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic [DATA_WIDTH+DIO_W-1:0] din_ext;
    logic [DIO_W+DATA_WIDTH-1:0] dout_ext;
    logic [PTR_W+IDX_W-1:0]      idx_ext;
    logic [PTR_W+IDX_W-1:0]      slot_ext;
    logic [PTR_W+IDX_W-1:0]      occ_ext;
    logic [PTR_W:0]              occ_sum;
    logic [PTR_W-1:0]            idx_p;
    logic                        idx_ok;
    logic [PTR_W-1:0]            head_inc;
    logic [PTR_W-1:0]            tail_dec;

    assign din_ext  = {{DATA_WIDTH{1'b0}}, req.data_in};
    assign dout_ext = {{DIO_W{1'b0}}, mem_rdata};
    assign idx_ext  = {{PTR_W{1'b0}}, req.index};
    assign idx_p    = idx_ext[PTR_W-1:0];
    assign idx_ok   = (idx_ext < (PTR_W + IDX_W)'(DEPTH))
                      && in_span(idx_p, head_reg, tail_reg);
    assign head_inc = ptr_inc(head_reg);
    assign tail_dec = ptr_dec(tail_reg);
    assign mv_src   = mv_down_reg ? (mv_pos_reg - 1'b1) : (mv_pos_reg + 1'b1);

    assign occ_sum  = (tail_reg >= head_reg)
                      ? ({1'b0, tail_reg} - {1'b0, head_reg})
                      : ({1'b0, tail_reg} - {1'b0, head_reg} + (PTR_W + 1)'(DEPTH));
    assign occ_ext  = {{IDX_W{1'b0}}, occ_sum[PTR_W-1:0]};
    assign slot_ext = {{IDX_W{1'b0}}, res_slot_reg};

    assign req.ready = (state_reg == rdq_pkg::S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cursor_next   = cursor_reg;
        mv_pos_next   = mv_pos_reg;
        mv_end_next   = mv_end_reg;
        mv_down_next  = mv_down_reg;
        res_ok_next   = res_ok_reg;
        res_rd_next   = res_rd_reg;
        res_slot_next = res_slot_reg;
        mem_we        = 1'b0;
        mem_waddr     = tail_reg;
        mem_wdata     = din_ext[DATA_WIDTH-1:0];
        mem_re        = 1'b0;
        mem_raddr     = head_reg;
        load_out      = 1'b0;

        case (state_reg)
            rdq_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next    = rdq_pkg::S_DONE;
                    res_ok_next   = 1'b0;
                    res_rd_next   = 1'b0;
                    res_slot_next = '0;
                    case (req.cmd)
                        rdq_pkg::CMD_PUSH:
                        begin
                            if (ptr_inc(tail_reg) != head_reg)
                            begin
                                mem_we        = 1'b1;
                                res_slot_next = tail_reg;
                                tail_next     = ptr_inc(tail_reg);
                                res_ok_next   = 1'b1;
                            end
                        end
                        rdq_pkg::CMD_SHIFT:
                        begin
                            if (head_reg != tail_reg)
                            begin
                                mem_re      = 1'b1;
                                head_next   = head_inc;
                                res_rd_next = 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        rdq_pkg::CMD_POP:
                        begin
                            if (head_reg != tail_reg)
                            begin
                                mem_re      = 1'b1;
                                mem_raddr   = tail_dec;
                                tail_next   = tail_dec;
                                res_rd_next = 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        rdq_pkg::CMD_REMOVE:
                        begin
                            if (idx_ok)
                            begin
                                res_ok_next = 1'b1;
                                mv_pos_next = idx_p;
                                if (idx_p >= head_reg)
                                begin
                                    // head run: shift older entries toward the tail
                                    mv_down_next = 1'b1;
                                    mv_end_next  = head_reg;
                                    head_next    = head_inc;
                                    if (cursor_reg < head_inc)
                                    begin
                                        cursor_next = head_inc;
                                    end
                                    if (idx_p != head_reg)
                                    begin
                                        state_next = rdq_pkg::S_MOVE_RD;
                                    end
                                end
                                else
                                begin
                                    // tail run: no wrap, tail is above the slot
                                    mv_down_next = 1'b0;
                                    mv_end_next  = tail_reg - 1'b1;
                                    tail_next    = tail_dec;
                                    if (cursor_reg >= tail_dec)
                                    begin
                                        cursor_next = head_reg;
                                    end
                                    if (idx_p != tail_reg - 1'b1)
                                    begin
                                        state_next = rdq_pkg::S_MOVE_RD;
                                    end
                                end
                            end
                        end
                        rdq_pkg::CMD_SEEK:
                        begin
                            if (in_span(cursor_reg, head_reg, tail_reg))
                            begin
                                mem_re        = 1'b1;
                                mem_raddr     = cursor_reg;
                                res_slot_next = cursor_reg;
                                cursor_next   = ptr_inc(cursor_reg);
                                res_rd_next   = 1'b1;
                                res_ok_next   = 1'b1;
                            end
                        end
                        rdq_pkg::CMD_RESTART:
                        begin
                            cursor_next = head_reg;
                            res_ok_next = 1'b1;
                        end
                        rdq_pkg::CMD_CLEAR:
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            cursor_next = '0;
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            rdq_pkg::S_MOVE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = mv_src;
                state_next = rdq_pkg::S_MOVE_WR;
            end
            rdq_pkg::S_MOVE_WR:
            begin
                // the next read lies beyond this write, so no forwarding is needed
                mem_we      = 1'b1;
                mem_waddr   = mv_pos_reg;
                mem_wdata   = mem_rdata;
                mv_pos_next = mv_src;
                state_next  = (mv_src == mv_end_reg) ? rdq_pkg::S_DONE
                                                     : rdq_pkg::S_MOVE_RD;
            end
            rdq_pkg::S_DONE:
            begin
                // hold until the response register is free or being drained
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = rdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdq_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cursor_reg <= cursor_next;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mv_pos_reg   <= mv_pos_next;
        mv_end_reg   <= mv_end_next;
        mv_down_reg  <= mv_down_next;
        res_ok_reg   <= res_ok_next;
        res_rd_reg   <= res_rd_next;
        res_slot_reg <= res_slot_next;
        if (load_out)
        begin
            out_ok_reg   <= res_ok_reg;
            out_data_reg <= res_rd_reg ? dout_ext[DIO_W-1:0] : '0;
            out_slot_reg <= slot_ext[IDX_W-1:0];
            out_occ_reg  <= occ_ext[IDX_W-1:0];
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.ok        = out_ok_reg;
    assign rsp.data_out  = out_data_reg;
    assign rsp.slot      = out_slot_reg;
    assign rsp.occupancy = out_occ_reg;

    rdq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (PTR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("command taken while another is in flight");

    a_walk_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rdq_pkg::S_MOVE_RD) |-> (mv_pos_reg != mv_end_reg))
        else $error("gap walk ran past its last slot");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == rdq_pkg::S_MOVE_WR)
                    || (req.valid && req.ready && req.cmd == rdq_pkg::CMD_PUSH)))
        else $error("memory written outside push or gap walk");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= LAST) && (tail_reg <= LAST) && (cursor_reg <= LAST))
        else $error("pointer beyond last slot");
`endif

endmodule

### bench/ring_deque_with_cursor_tb.sv
`timescale 1ns / 100ps
// Testbench for ring_deque_with_cursor: directed table, then random commands checked
// against a local model of the deque. Depends on rdq_pkg, rdq_req_if, rdq_rsp_if.
module ring_deque_with_cursor_tb;

    localparam int          DEPTH       = 16;
    localparam logic [2:0]  CMD_UNKNOWN = 3'd7;
    localparam int unsigned RUN_LIMIT   = 600000;
    localparam int          DRAIN_WAIT  = 40;
    localparam int          RAND_ITEMS  = 430;

    typedef struct packed {
        logic        ok;
        logic [31:0] data;
        logic [3:0]  slot;
        logic [3:0]  occ;
    } deque_rsp_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] data;
        logic [3:0]  idx;
        int          reps;
        bit          typed;
        logic        w_ok;
        logic [31:0] w_data;
        logic [3:0]  w_slot;
        logic [3:0]  w_occ;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rdq_req_if req_ch ();
    rdq_rsp_if rsp_ch ();

    ring_deque_with_cursor #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // Local copy of the deque
    logic [31:0] slot_mem [DEPTH];
    logic [3:0]  head_q;
    logic [3:0]  tail_q;
    logic [3:0]  cursor_q;

    deque_rsp_t  pending_rsp [$];
    int          errors = 0;
    int unsigned cycle_cnt = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    dir_row_t    plan [25];

    function automatic bit slot_live(input logic [3:0] p);
        if (head_q <= tail_q)
            return (p >= head_q) && (p < tail_q);
        return (p >= head_q) || (p < tail_q);
    endfunction

    function automatic deque_rsp_t apply_deque_cmd(input logic [2:0] c,
                                                   input logic [31:0] din,
                                                   input logic [3:0] idx);
        deque_rsp_t r;
        logic [3:0] j;
        r = '0;
        case (c)
            rdq_pkg::CMD_PUSH:
                if (tail_q + 4'd1 != head_q)
                begin
                    slot_mem[tail_q] = din;
                    r.slot = tail_q;
                    tail_q = tail_q + 4'd1;
                    r.ok = 1'b1;
                end
            rdq_pkg::CMD_SHIFT:
                if (head_q != tail_q)
                begin
                    r.data = slot_mem[head_q];
                    head_q = head_q + 4'd1;
                    r.ok = 1'b1;
                end
            rdq_pkg::CMD_POP:
                if (head_q != tail_q)
                begin
                    tail_q = tail_q - 4'd1;
                    r.data = slot_mem[tail_q];
                    r.ok = 1'b1;
                end
            rdq_pkg::CMD_REMOVE:
                if (slot_live(idx))
                begin
                    r.ok = 1'b1;
                    if (idx >= head_q)
                    begin
                        // close the gap from the head side
                        for (j = idx; j != head_q; j = j - 4'd1)
                            slot_mem[j] = slot_mem[j - 4'd1];
                        head_q = head_q + 4'd1;
                        if (cursor_q < head_q)
                            cursor_q = head_q;
                    end
                    else
                    begin
                        // wrapped span, slot below the tail: pull later entries down
                        for (j = idx; j + 1 < tail_q; j = j + 4'd1)
                            slot_mem[j] = slot_mem[j + 4'd1];
                        tail_q = tail_q - 4'd1;
                        if (cursor_q >= tail_q)
                            cursor_q = head_q;
                    end
                end
            rdq_pkg::CMD_SEEK:
                if (head_q != tail_q && slot_live(cursor_q))
                begin
                    r.data = slot_mem[cursor_q];
                    r.slot = cursor_q;
                    cursor_q = cursor_q + 4'd1;
                    r.ok = 1'b1;
                end
            rdq_pkg::CMD_RESTART:
            begin
                cursor_q = head_q;
                r.ok = 1'b1;
            end
            rdq_pkg::CMD_CLEAR:
            begin
                head_q = '0;
                tail_q = '0;
                cursor_q = '0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.occ = tail_q - head_q;
        return r;
    endfunction

    // Present one command, hold it until taken, then log what must come back
    task automatic issue_cmd(input logic [2:0] c, input logic [31:0] d, input logic [3:0] i,
                             input bit typed, input deque_rsp_t fixed);
        deque_rsp_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= c;
        req_ch.data_in <= d;
        req_ch.index   <= i;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        r = apply_deque_cmd(c, d, i);
        pending_rsp.push_back(typed ? fixed : r);
    endtask

    function automatic void note_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : rsp_check
        deque_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display({"%0t: unexpected transaction, expected none, ",
                          "actual ok=%b data=%h slot=%0d occ=%0d"},
                         $time, rsp_ch.ok, rsp_ch.data_out, rsp_ch.slot, rsp_ch.occupancy);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                note_field("ok", want.ok, rsp_ch.ok);
                note_field("data_out", want.data, rsp_ch.data_out);
                note_field("slot", want.slot, rsp_ch.slot);
                note_field("occupancy", want.occ, rsp_ch.occupancy);
            end
        end
    end

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        wait (cycle_cnt >= RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        deque_rsp_t  fixed;
        logic [2:0]  c;
        logic [3:0]  i;
        logic [3:0]  fill_now;
        int          roll;
        int          push_w;
        req_ch.valid   <= 1'b0;
        req_ch.cmd     <= rdq_pkg::CMD_PUSH;
        req_ch.data_in <= '0;
        req_ch.index   <= '0;
        head_q   = '0;
        tail_q   = '0;
        cursor_q = '0;
        foreach (slot_mem[k])
            slot_mem[k] = '0;

        //  cmd                    data_in        idx  reps typed ok  data_out      slot occ
        plan = '{
            '{rdq_pkg::CMD_SHIFT,   32'h0000_0000, 4'd0,  1, 1, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_POP,     32'h0000_0000, 4'd0,  1, 1, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_SEEK,    32'h0000_0000, 4'd0,  1, 1, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_REMOVE,  32'h0000_0000, 4'd5,  1, 1, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{CMD_UNKNOWN,          32'hDEAD_BEEF, 4'd15, 1, 1, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_RESTART, 32'h0000_0000, 4'd0,  1, 1, 1'b1, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_PUSH,    32'hFFFF_FFFF, 4'd0,  1, 1, 1'b1, 32'h0000_0000, 4'd0, 4'd1},
            '{rdq_pkg::CMD_PUSH,    32'h0000_0000, 4'd0,  1, 1, 1'b1, 32'h0000_0000, 4'd1, 4'd2},
            '{rdq_pkg::CMD_PUSH,    32'hA5A5_A5A0, 4'd0, 13, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_PUSH,    32'h1234_5678, 4'd0,  1, 1, 1'b0, 32'h0000_0000, 4'd0, 4'd15},
            '{rdq_pkg::CMD_SEEK,    32'h0000_0000, 4'd0,  1, 1, 1'b1, 32'hFFFF_FFFF, 4'd0, 4'd15},
            '{rdq_pkg::CMD_SEEK,    32'h0000_0000, 4'd0,  3, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_SHIFT,   32'h0000_0000, 4'd0,  1, 1, 1'b1, 32'hFFFF_FFFF, 4'd0, 4'd14},
            '{rdq_pkg::CMD_SHIFT,   32'h0000_0000, 4'd0,  5, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_SEEK,    32'h0000_0000, 4'd0,  1, 1, 1'b0, 32'h0000_0000, 4'd0, 4'd9},
            '{rdq_pkg::CMD_RESTART, 32'h0000_0000, 4'd0,  1, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_PUSH,    32'h5A5A_5A50, 4'd0,  4, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_REMOVE,  32'h0000_0000, 4'd1,  1, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_REMOVE,  32'h0000_0000, 4'd8,  1, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_REMOVE,  32'h0000_0000, 4'd4,  1, 1, 1'b0, 32'h0000_0000, 4'd0, 4'd11},
            '{rdq_pkg::CMD_SEEK,    32'h0000_0000, 4'd0, 12, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_POP,     32'h0000_0000, 4'd0,  3, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_REMOVE,  32'h0000_0000, 4'd7,  1, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_REMOVE,  32'h0000_0000, 4'd14, 1, 0, 1'b0, 32'h0000_0000, 4'd0, 4'd0},
            '{rdq_pkg::CMD_CLEAR,   32'h0000_0000, 4'd0,  1, 1, 1'b1, 32'h0000_0000, 4'd0, 4'd0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 12;
        rx_idle_pct = 87;
        foreach (plan[r])
        begin
            fixed = '{plan[r].w_ok, plan[r].w_data, plan[r].w_slot, plan[r].w_occ};
            for (int k = 0; k < plan[r].reps; k++)
                issue_cmd(plan[r].cmd, plan[r].data + k, plan[r].idx, plan[r].typed, fixed);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 87 : 0;
            rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 12 : 0;
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                // alternate fill-heavy and drain-heavy stretches to reach full and empty
                push_w = ((n / 48) % 2 == 0) ? 50 : 22;
                roll = $urandom_range(99);
                if (roll < push_w)
                    c = rdq_pkg::CMD_PUSH;
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 17)
                        c = rdq_pkg::CMD_SHIFT;
                    else if (roll < 34)
                        c = rdq_pkg::CMD_POP;
                    else if (roll < 60)
                        c = rdq_pkg::CMD_REMOVE;
                    else if (roll < 88)
                        c = rdq_pkg::CMD_SEEK;
                    else if (roll < 94)
                        c = rdq_pkg::CMD_RESTART;
                    else if (roll < 97)
                        c = rdq_pkg::CMD_CLEAR;
                    else
                        c = CMD_UNKNOWN;
                end
                fill_now = tail_q - head_q;
                i = 4'($urandom_range(15));
                // aim most removes at a live slot
                if (c == rdq_pkg::CMD_REMOVE && fill_now != 0 && $urandom_range(99) < 85)
                    i = head_q + 4'($urandom_range(fill_now - 1));
                issue_cmd(c, $urandom, i, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
